/* hdl/mbhd_pkg.sv */
package mbhd_pkg;

    // header geometry and field limits
    localparam logic [7:0]  HDR_LEN      = 8'd128;
    localparam logic [31:0] HDR_LEN_FILE = 32'd128;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  VER_II       = 8'h81;
    localparam logic [7:0]  VER_III      = 8'h82;
    localparam logic [7:0]  NAME_MAX_LEN = 8'd63;

    // byte positions inside the 128-byte header
    localparam logic [6:0] POS_OLD_VER = 7'd0;
    localparam logic [6:0] POS_NAME    = 7'd1;
    localparam logic [6:0] POS_ZERO_A  = 7'd74;
    localparam logic [6:0] POS_ZERO_B  = 7'd82;
    localparam logic [6:0] POS_WRITER  = 7'd122;
    localparam logic [6:0] POS_READER  = 7'd123;
    localparam logic [6:0] POS_CRC_HI  = 7'd124;
    localparam logic [6:0] POS_CRC_LO  = 7'd125;

    // one input request
    typedef struct packed {
        logic [7:0]  byte_value;
        logic        last_byte;
        logic [31:0] file_length;
    } mbhd_item_t;

    // one byte of crc-16/xmodem, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/mbhd_item_if.sv */
interface mbhd_item_if;
    import mbhd_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [31:0] file_length;

    modport source (output valid, output byte_value, output last_byte, output file_length,
                    input ready);
    modport sink   (input valid, input byte_value, input last_byte, input file_length,
                    output ready);
endinterface

interface mbhd_result_if;
    logic       valid;
    logic       ready;
    logic       header_found;
    logic [7:0] payload_offset;

    modport source (output valid, output header_found, output payload_offset, input ready);
    modport sink   (input valid, input header_found, input payload_offset, output ready);
endinterface

/* hdl/macbinary_header_detector.sv */
// MacBinary II/III header detector. Feed the leading bytes of a file in order, one request
// per byte, with last_byte set on the final byte supplied; that request yields one result
// giving header_found and payload_offset (128 when found, else 0), after which the block is
// ready for the next file. Bytes past the first 128 are ignored. A request is taken every
// cycle unless the output stalls: each byte goes through an input register and the crc and
// field checks, and a last byte's verdict is then held in the result register. The only stall
// comes from the output register when a result is waiting and the sink is not ready.
module macbinary_header_detector
    import mbhd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mbhd_item_if.sink     item,
    mbhd_result_if.source result
);

    logic       s1_valid_reg;
    mbhd_item_t s1_reg;
    logic       s1_fire;
    logic       out_free;
    logic       out_valid_reg;
    logic       out_found_reg;
    logic [7:0] out_offset_reg;
    logic       found;

    // a byte leaves stage one unless its result has nowhere to go
    assign out_free = ~out_valid_reg | result.ready;
    assign s1_fire  = s1_valid_reg & (~s1_reg.last_byte | out_free);
    assign item.ready = ~s1_valid_reg | s1_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_reg <= '{byte_value: item.byte_value, last_byte: item.last_byte,
                        file_length: item.file_length};
        end
    end

    // header state and checks
    mbhd_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_fire),
        .item  (s1_reg),
        .found (found)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_reg.last_byte)
        begin
            out_found_reg  <= found;
            out_offset_reg <= found ? HDR_LEN : 8'd0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.header_found   = out_found_reg;
    assign result.payload_offset = out_offset_reg;

    // offset always agrees with the verdict
    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_offset_reg == (out_found_reg ? HDR_LEN : 8'd0)))
        else $error("payload offset disagrees with header_found");

    // a header is never reported for a short file
    a_short_file: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_reg.last_byte && found) |-> (s1_reg.file_length > HDR_LEN_FILE))
        else $error("header reported for file of 128 bytes or less");

    // an empty input stage always takes a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> item.ready)
        else $error("input stage empty but not ready");

    // a waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_found_reg)))
        else $error("pending result lost");

endmodule

/* hdl/mbhd_tracker.sv */
module mbhd_tracker
    import mbhd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  mbhd_item_t item,
    output logic       found
);

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic        crc_hi_reg, crc_hi_next;
    logic        in_hdr;
    logic [6:0]  idx;
    logic [7:0]  b;
    logic        field_bad;

    assign in_hdr = ~pos_reg[7];
    assign idx    = pos_reg[6:0];
    assign b      = item.byte_value;

    // fixed field checks at their positions
    always_comb
    begin
        field_bad = 1'b0;
        if (idx == POS_OLD_VER && b != 8'd0)
            field_bad = 1'b1;
        if (idx == POS_NAME && (b == 8'd0 || b > NAME_MAX_LEN))
            field_bad = 1'b1;
        if ((idx == POS_ZERO_A || idx == POS_ZERO_B) && b != 8'd0)
            field_bad = 1'b1;
        if (idx == POS_WRITER && b != VER_II && b != VER_III)
            field_bad = 1'b1;
        if (idx == POS_READER && b != VER_II)
            field_bad = 1'b1;
        if (idx == POS_CRC_LO && (!crc_hi_reg || b != crc_reg[7:0]))
            field_bad = 1'b1;
    end

    // next header state for this byte
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        valid_next  = valid_reg;
        crc_hi_next = crc_hi_reg;
        if (in_hdr)
        begin
            pos_next   = pos_reg + 8'd1;
            valid_next = valid_reg & ~field_bad;
            if (idx < POS_CRC_HI)
                crc_next = crc_byte(crc_reg, b);
            else if (idx == POS_CRC_HI)
                crc_hi_next = (b == crc_reg[15:8]);
        end
    end

    // verdict on the last byte
    assign found = pos_next[7] && (item.file_length > HDR_LEN_FILE) && valid_next;

    // state registers, cleared after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            crc_reg    <= 16'd0;
            valid_reg  <= 1'b1;
            crc_hi_reg <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg    <= 8'd0;
                crc_reg    <= 16'd0;
                valid_reg  <= 1'b1;
                crc_hi_reg <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                valid_reg  <= valid_next;
                crc_hi_reg <= crc_hi_next;
            end
        end
    end

endmodule
